>>> design/rmq_pkg.sv
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_M00   = 2'd1;
    localparam logic [1:0] CASE_M11   = 2'd2;
    localparam logic [1:0] CASE_M22   = 2'd3;

endpackage

>>> design/rotation_matrix_to_quaternion_unit.sv
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_ready | m00 .. m22
// out     | output    | out_valid/out_ready | qx qy qz qw case_taken degenerate
//
// One matrix per cycle sustained while the output is not stalled.
// The depth follows from the square root (one result bit per stage) and the
// three restoring dividers (one quotient bit per stage), all pipelined.
// Reset clears only the valid bits of the stages.
// A stall at the output freezes the whole pipe; nothing is lost or repeated.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] qx,
    output logic signed [DATA_WIDTH-1:0] qy,
    output logic signed [DATA_WIDTH-1:0] qz,
    output logic signed [DATA_WIDTH-1:0] qw,
    output logic [1:0]                   case_taken,
    output logic                         degenerate
);
    import rmq_pkg::*;

    // radicand: 1 + up to 3*|m| -> DATA_WIDTH+3 bits signed
    localparam int RW  = DATA_WIDTH + 3;
    // square root operand width (even)
    localparam int NW0 = RW - 1 + FRAC_BITS;
    localparam int NW  = NW0 + (NW0 % 2);
    localparam int SQ_STEPS = NW / 2;
    localparam int SW  = SQ_STEPS;          // root width
    // pair magnitude: DATA_WIDTH+1 bits; dividend = mag << FRAC_BITS
    localparam int PW  = DATA_WIDTH + 1;
    localparam int DW  = PW + FRAC_BITS;    // dividend width
    localparam int DV_STEPS = DW;
    localparam int VW  = SW + 1;            // divisor 2r width
    localparam int NST = SQ_STEPS + DV_STEPS + 2;
    localparam logic [DW-1:0] QCAP = DW'(1) << (DATA_WIDTH - 1);

    typedef struct packed {
        logic [1:0]    cs;
        logic          degen;
        logic [2:0]    neg;
    } ctl_t;

    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // ---------------- stage 0: case selection and pair sums
    logic signed [RW-1:0] e00, e11, e22, tr, one_s, rad_c;
    logic signed [PW-1:0] pa_c, pb_c, pc_c;
    logic [1:0] cs_c;
    always_comb
    begin
        e00   = RW'(m00);
        e11   = RW'(m11);
        e22   = RW'(m22);
        one_s = RW'(1) <<< FRAC_BITS;
        tr    = e00 + e11 + e22;
        if (tr > 0)
        begin
            cs_c = CASE_TRACE;  rad_c = one_s + tr;
            pa_c = PW'(m21) - PW'(m12); pb_c = PW'(m02) - PW'(m20);
            pc_c = PW'(m10) - PW'(m01);
        end
        else if (m00 > m11 && m00 > m22)
        begin
            cs_c = CASE_M00;    rad_c = one_s + e00 - e11 - e22;
            pa_c = PW'(m21) - PW'(m12); pb_c = PW'(m01) + PW'(m10);
            pc_c = PW'(m02) + PW'(m20);
        end
        else if (m11 > m22)
        begin
            cs_c = CASE_M11;    rad_c = one_s + e11 - e00 - e22;
            pa_c = PW'(m02) - PW'(m20); pb_c = PW'(m01) + PW'(m10);
            pc_c = PW'(m12) + PW'(m21);
        end
        else
        begin
            cs_c = CASE_M22;    rad_c = one_s + e22 - e00 - e11;
            pa_c = PW'(m10) - PW'(m01); pb_c = PW'(m02) + PW'(m20);
            pc_c = PW'(m12) + PW'(m21);
        end
    end

    // pipe of valid bits
    logic [NST-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end
    assign out_valid = vld_reg[NST-1];

    // stage 1 registers
    ctl_t           c1_reg;
    logic [NW-1:0]  n1_reg;
    logic [PW-1:0]  mg1_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c1_reg.cs    <= cs_c;
            c1_reg.degen <= (rad_c <= 0);
            c1_reg.neg   <= {pc_c[PW-1], pb_c[PW-1], pa_c[PW-1]};
            n1_reg       <= (rad_c <= 0) ? '0 :
                            NW'(unsigned'(rad_c[RW-2:0])) << FRAC_BITS;
            mg1_reg[0]   <= pa_c[PW-1] ? -pa_c : pa_c;
            mg1_reg[1]   <= pb_c[PW-1] ? -pb_c : pb_c;
            mg1_reg[2]   <= pc_c[PW-1] ? -pc_c : pc_c;
        end
    end

    // ---------------- square root: one root bit per stage (digit recurrence)
    logic [NW-1:0]  sq_n_reg   [SQ_STEPS+1];
    logic [SW-1:0]  sq_r_reg   [SQ_STEPS+1];
    logic [SW+1:0]  sq_rem_reg [SQ_STEPS+1];
    ctl_t           sq_c_reg   [SQ_STEPS+1];
    logic [PW-1:0]  sq_m_reg   [SQ_STEPS+1][3];

    always_comb
    begin
        sq_n_reg[0]   = n1_reg;
        sq_r_reg[0]   = '0;
        sq_rem_reg[0] = '0;
        sq_c_reg[0]   = c1_reg;
        sq_m_reg[0]   = mg1_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sq
            logic [SW+1:0] rem_sh, trial;
            always_comb
            begin
                rem_sh = {sq_rem_reg[gi][SW-1:0], sq_n_reg[gi][NW-1 -: 2]};
                trial  = {sq_r_reg[gi], 2'b01};
            end
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    sq_n_reg[gi+1] <= sq_n_reg[gi] << 2;
                    sq_c_reg[gi+1] <= sq_c_reg[gi];
                    sq_m_reg[gi+1] <= sq_m_reg[gi];
                    if (rem_sh >= trial)
                    begin
                        sq_rem_reg[gi+1] <= rem_sh - trial;
                        sq_r_reg[gi+1]   <= {sq_r_reg[gi][SW-2:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg[gi+1] <= rem_sh;
                        sq_r_reg[gi+1]   <= {sq_r_reg[gi][SW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // ---------------- three dividers: one quotient bit per stage
    logic [VW-1:0]  dv_d_reg   [DV_STEPS+1];
    logic [SW-1:0]  dv_r_reg   [DV_STEPS+1];
    ctl_t           dv_c_reg   [DV_STEPS+1];
    logic [DW-1:0]  dv_n_reg   [DV_STEPS+1][3];
    logic [VW-1:0]  dv_rem_reg [DV_STEPS+1][3];

    always_comb
    begin
        dv_r_reg[0] = sq_r_reg[SQ_STEPS];
        dv_d_reg[0] = {sq_r_reg[SQ_STEPS], 1'b0};
        dv_c_reg[0] = sq_c_reg[SQ_STEPS];
        for (int k = 0; k < 3; k++)
        begin
            dv_n_reg[0][k]   = DW'(sq_m_reg[SQ_STEPS][k]) << FRAC_BITS;
            dv_rem_reg[0][k] = '0;
        end
    end

    generate
        for (gi = 0; gi < DV_STEPS; gi++)
        begin : g_dv
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    dv_d_reg[gi+1] <= dv_d_reg[gi];
                    dv_r_reg[gi+1] <= dv_r_reg[gi];
                    dv_c_reg[gi+1] <= dv_c_reg[gi];
                end
            end
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                logic [VW:0] rs;
                assign rs = {dv_rem_reg[gi][k], dv_n_reg[gi][k][DW-1]};
                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        if (rs >= {1'b0, dv_d_reg[gi]})
                        begin
                            dv_rem_reg[gi+1][k] <= VW'(rs - {1'b0, dv_d_reg[gi]});
                            dv_n_reg[gi+1][k]   <= {dv_n_reg[gi][k][DW-2:0], 1'b1};
                        end
                        else
                        begin
                            dv_rem_reg[gi+1][k] <= VW'(rs);
                            dv_n_reg[gi+1][k]   <= {dv_n_reg[gi][k][DW-2:0], 1'b0};
                        end
                    end
                end
            end
        end
    endgenerate

    // ---------------- final stage: saturate, sign and place
    ctl_t                  cf;
    logic [DW-1:0]         qc [3];
    logic signed [DATA_WIDTH-1:0] qs [3];
    logic signed [DATA_WIDTH-1:0] qd;
    logic signed [DATA_WIDTH-1:0] res [4];
    logic [SW-1:0]         half;
    always_comb
    begin
        cf   = dv_c_reg[DV_STEPS];
        half = dv_r_reg[DV_STEPS] >> 1;
        for (int k = 0; k < 3; k++)
        begin
            qc[k] = (dv_n_reg[DV_STEPS][k] > QCAP) ? QCAP : dv_n_reg[DV_STEPS][k];
            if (cf.neg[k])
                qs[k] = DATA_WIDTH'(-qc[k]);
            else if (qc[k] == QCAP)
                qs[k] = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            else
                qs[k] = DATA_WIDTH'(qc[k]);
        end
        if (SW > DATA_WIDTH - 1 && (half >> (DATA_WIDTH - 1)) != '0)
            qd = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else
            qd = DATA_WIDTH'(half);
        // pa goes to index 3 except in trace case (then x)
        res[0] = '0; res[1] = '0; res[2] = '0; res[3] = '0;
        case (cf.cs)
            CASE_TRACE: begin res[3] = qd; res[0] = qs[0]; res[1] = qs[1]; res[2] = qs[2]; end
            CASE_M00:   begin res[0] = qd; res[3] = qs[0]; res[1] = qs[1]; res[2] = qs[2]; end
            CASE_M11:   begin res[1] = qd; res[3] = qs[0]; res[0] = qs[1]; res[2] = qs[2]; end
            default:    begin res[2] = qd; res[3] = qs[0]; res[0] = qs[1]; res[1] = qs[2]; end
        endcase
        if (cf.degen)
        begin
            res[0] = '0; res[1] = '0; res[2] = '0; res[3] = '0;
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qx         <= res[0];
            qy         <= res[1];
            qz         <= res[2];
            qw         <= res[3];
            case_taken <= cf.cs;
            degenerate <= cf.degen;
        end
    end

    // a degenerate result carries an all-zero quaternion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
        else $error("degenerate result with nonzero quaternion");

    // trace case is never degenerate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && case_taken == CASE_TRACE |-> !degenerate)
        else $error("trace case flagged degenerate");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(qw) && $stable(case_taken))
        else $error("stalled result changed");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import rmq_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int N_RANDOM = 1100;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [DW-1:0] entry_t;

    typedef struct {
        entry_t m[9];
    } matrix_t;

    typedef struct {
        entry_t     qx;
        entry_t     qy;
        entry_t     qz;
        entry_t     qw;
        logic [1:0] case_taken;
        logic       degenerate;
    } quat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic out_valid;
    logic out_ready;
    entry_t qx, qy, qz, qw;
    logic [1:0] case_taken;
    logic degenerate;

    matrix_t pending_matrices[$];
    quat_t   expected_quats[$];
    int      error_count;
    int      cycle_count;
    int      hold_off;
    bit      stimulus_done;

    rotation_matrix_to_quaternion_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .m00        (m00),
        .m01        (m01),
        .m02        (m02),
        .m10        (m10),
        .m11        (m11),
        .m12        (m12),
        .m20        (m20),
        .m21        (m21),
        .m22        (m22),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .qx         (qx),
        .qy         (qy),
        .qz         (qz),
        .qw         (qw),
        .case_taken (case_taken),
        .degenerate (degenerate)
    );

    always #2 clk = ~clk;

    // Short gaps mostly, a long one now and then
    function automatic int gap_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        else if (sel < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Integer square root, bit-by-bit restoring method
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_entry(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // (p << FB) / 2r truncated toward zero, then clamped
    function automatic entry_t pair_quotient(longint p, longint unsigned r);
        longint unsigned mag;
        longint unsigned q;
        longint s;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        q = (mag << FB) / (r << 1);
        if (q > 32768)
            q = 32768;
        s = (p < 0) ? -longint'(q) : longint'(q);
        return entry_t'(clamp_entry(s));
    endfunction

    // Shepperd's case selection and component computation
    function automatic quat_t matrix_to_quat(matrix_t a);
        longint e[9];
        longint trace;
        longint rad;
        longint pa, pb, pc;
        longint unsigned r;
        entry_t q[4];
        int dom, ia, ib, ic;
        quat_t res;
        for (int k = 0; k < 9; k++)
            e[k] = a.m[k];
        trace = e[0] + e[4] + e[8];
        if (trace > 0)
        begin
            res.case_taken = CASE_TRACE; rad = (1 << FB) + trace;
            dom = 3; ia = 0; ib = 1; ic = 2;
            pa = e[7] - e[5]; pb = e[2] - e[6]; pc = e[3] - e[1];
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            res.case_taken = CASE_M00; rad = (1 << FB) + e[0] - e[4] - e[8];
            dom = 0; ia = 3; ib = 1; ic = 2;
            pa = e[7] - e[5]; pb = e[1] + e[3]; pc = e[2] + e[6];
        end
        else if (e[4] > e[8])
        begin
            res.case_taken = CASE_M11; rad = (1 << FB) + e[4] - e[0] - e[8];
            dom = 1; ia = 3; ib = 0; ic = 2;
            pa = e[2] - e[6]; pb = e[1] + e[3]; pc = e[5] + e[7];
        end
        else
        begin
            res.case_taken = CASE_M22; rad = (1 << FB) + e[8] - e[0] - e[4];
            dom = 2; ia = 3; ib = 0; ic = 1;
            pa = e[3] - e[1]; pb = e[2] + e[6]; pc = e[5] + e[7];
        end
        for (int k = 0; k < 4; k++)
            q[k] = '0;
        res.degenerate = (rad <= 0);
        if (rad > 0)
        begin
            r = int_sqrt(longint'(rad) << FB);
            q[dom] = entry_t'(clamp_entry(longint'(r >> 1)));
            q[ia] = pair_quotient(pa, r);
            q[ib] = pair_quotient(pb, r);
            q[ic] = pair_quotient(pc, r);
        end
        res.qx = q[0];
        res.qy = q[1];
        res.qz = q[2];
        res.qw = q[3];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic matrix_t make_matrix(longint d0, longint d1, longint d2,
                                            longint o0, longint o1, longint o2,
                                            longint o3, longint o4, longint o5);
        matrix_t a;
        a.m[0] = entry_t'(d0); a.m[4] = entry_t'(d1); a.m[8] = entry_t'(d2);
        a.m[1] = entry_t'(o0); a.m[2] = entry_t'(o1); a.m[3] = entry_t'(o2);
        a.m[5] = entry_t'(o3); a.m[6] = entry_t'(o4); a.m[7] = entry_t'(o5);
        return a;
    endfunction

    // Rough rotation-like matrix: positive diagonal or one chosen dominant diagonal entry, random entries elsewhere
    function automatic matrix_t rotation_like();
        matrix_t a;
        int sel;
        for (int k = 0; k < 9; k++)
            a.m[k] = entry_t'($signed($urandom_range(0, 32767)) - 16384);
        sel = $urandom_range(0, 3);
        if (sel == 0)
        begin
            for (int k = 0; k < 9; k += 4)
                a.m[k] = entry_t'($urandom_range(4000, 16384));
        end
        else
        begin
            for (int k = 0; k < 9; k += 4)
                a.m[k] = entry_t'(-$signed($urandom_range(6000, 16384)));
            a.m[(sel - 1) * 4] = entry_t'($urandom_range(0, 16384));
        end
        return a;
    endfunction

    // Fill the stimulus queue: directed corners first, then random
    initial
    begin
        matrix_t a;
        int sel;
        pending_matrices.push_back(make_matrix(16384, 16384, 16384, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(make_matrix(16384, -16384, -16384, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(make_matrix(-16384, 16384, -16384, 0, 0, 0, 0, 0, 0));
        pending_matrices.push_back(make_matrix(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0));
        // ties on the diagonal
        pending_matrices.push_back(make_matrix(-100, -100, -200, 5, 6, 7, 8, 9, 10));
        pending_matrices.push_back(make_matrix(-100, -200, -100, 5, 6, 7, 8, 9, 10));
        pending_matrices.push_back(make_matrix(-200, -100, -100, 5, 6, 7, 8, 9, 10));
        pending_matrices.push_back(make_matrix(0, 0, 0, 1, 2, 3, 4, 5, 6));
        // full-scale diagonal entries in the M00, M11 and M22 branches
        pending_matrices.push_back(make_matrix(-20000, -32768, 32767, 1, 1, 1, 1, 1, 1));
        pending_matrices.push_back(make_matrix(-32768, 0, -1, 7, 7, 7, 7, 7, 7));
        pending_matrices.push_back(make_matrix(32767, -32768, -32768, 1, 2, 3, 4, 5, 6));
        pending_matrices.push_back(make_matrix(-32768, -32768, -32768,
                                               32767, 32767, 32767, 32767, 32767, 32767));
        pending_matrices.push_back(make_matrix(-32768, -32768, -32768,
                                               -32768, -32768, -32768, -32768, -32768, -32768));
        // quotient corners: some with small radicand and saturating off-diagonal quotients
        pending_matrices.push_back(make_matrix(-16383, -32768, 16383,
                                               32767, -32768, 32767, -32768, 32767, -32768));
        pending_matrices.push_back(make_matrix(1, 0, 0, -32768, 32767, 32767,
                                               -32768, -32768, 32767));
        pending_matrices.push_back(make_matrix(32767, 32767, 32767,
                                               -32768, -32768, -32768, 32767, 32767, 32767));
        pending_matrices.push_back(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_matrices.push_back(make_matrix(-1, 0, 0, -32768, 32767, 32767, -32768,
                                               32767, -32768));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                a = rotation_like();
            else if (sel < 8)
                for (int k = 0; k < 9; k++)
                    a.m[k] = entry_t'($urandom());
            else
                for (int k = 0; k < 9; k++)
                    a.m[k] = ($urandom_range(0, 1) != 0) ? entry_t'(-32768) :
                             entry_t'($signed($urandom_range(0, 65535)) >>> 4);
            pending_matrices.push_back(a);
        end
    end

    // Clock, reset, and end of run
    initial
    begin
        int settle;
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        stimulus_done = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done && expected_quats.size() == 0);
        settle = 0;
        while (settle < DRAIN_CYCLES)
        begin
            @(posedge clk);
            settle++;
        end
        if (error_count == 0)
            $display("rotation_matrix_to_quaternion_unit: match");
        else
            $display("rotation_matrix_to_quaternion_unit: mismatch");
        $finish;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rotation_matrix_to_quaternion_unit: mismatch");
            $finish;
        end
    end

    initial cycle_count = 0;

    // Input acceptance seen at the rising edge
    logic in_ready_sampled;
    initial in_ready_sampled = 1'b0;
    always @(posedge clk)
        in_ready_sampled <= in_ready;

    // Driver: offer the next matrix at the falling edge, hold until accepted
    int send_gap;
    initial
    begin
        in_valid = 1'b0;
        send_gap = 0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready_sampled)
            begin
                expected_quats.push_back(matrix_to_quat(pending_matrices.pop_front()));
                if (pending_matrices.size() == 0)
                    stimulus_done <= 1'b1;
                send_gap = gap_length();
            end
            if (!(in_valid && !in_ready_sampled))
            begin
                if (send_gap == 0 && pending_matrices.size() != 0)
                begin
                    m00 <= pending_matrices[0].m[0]; m01 <= pending_matrices[0].m[1];
                    m02 <= pending_matrices[0].m[2]; m10 <= pending_matrices[0].m[3];
                    m11 <= pending_matrices[0].m[4]; m12 <= pending_matrices[0].m[5];
                    m20 <= pending_matrices[0].m[6]; m21 <= pending_matrices[0].m[7];
                    m22 <= pending_matrices[0].m[8];
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // Receiver readiness: random stalls plus one long hold-off to fill the pipe
    int recv_gap;
    initial
    begin
        out_ready = 1'b0;
        recv_gap = 0;
        hold_off = 0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cycle_count == 300)
                hold_off = 150;
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ((cycle_count / 500) % 3 != 2)
                    recv_gap = gap_length();
            end
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        quat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_quats.size() == 0)
            begin
                $display("[%0t] result with no matrix outstanding", $time);
                error_count++;
            end
            else
            begin
                want = expected_quats.pop_front();
                if (qx !== want.qx) report_mismatch("qx", qx, want.qx);
                if (qy !== want.qy) report_mismatch("qy", qy, want.qy);
                if (qz !== want.qz) report_mismatch("qz", qz, want.qz);
                if (qw !== want.qw) report_mismatch("qw", qw, want.qw);
                if (case_taken !== want.case_taken)
                    report_mismatch("case_taken", case_taken, want.case_taken);
                if (degenerate !== want.degenerate)
                    report_mismatch("degenerate", degenerate, want.degenerate);
            end
        end
    end

endmodule
